[rtl/bdq_pkg.sv]
// ----------------------------------------------------------------------------
// bdq_pkg: shared types and constants for the bounded deque
// Command and status codes, cell operations, beat structs and sizing.
// ----------------------------------------------------------------------------
package bdq_pkg;

    localparam int DEPTH        = 128;
    localparam int WORD_BITS    = 32;
    localparam int PAYLOAD_BITS = 32;
    localparam int CAP_BITS     = 8;
    localparam int FILL_BITS    = 8;
    localparam int CNT_W        = $clog2(DEPTH + 1);
    localparam int LIM_W        = (CNT_W > CAP_BITS) ? CNT_W : CAP_BITS;
    localparam int GROUP_SIZE   = 16;
    localparam int GROUPS       = (DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;

    localparam logic [CAP_BITS-1:0] CAPACITY_RESET = CAP_BITS'(100);

    typedef enum logic [1:0] {
        CMD_BACK_PUSH  = 2'd0,
        CMD_FRONT_PUSH = 2'd1,
        CMD_BACK_POP   = 2'd2,
        CMD_FRONT_POP  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_BACK_PUSH,
        OP_FRONT_PUSH,
        OP_BACK_POP,
        OP_FRONT_POP
    } cell_op_t;

    typedef enum logic {
        S_IDLE,
        S_FIN
    } state_t;

    typedef struct packed {
        cmd_t                    cmd;
        logic [PAYLOAD_BITS-1:0] push_word;
    } in_item_t;

    typedef struct packed {
        logic [PAYLOAD_BITS-1:0] pop_word;
        status_t                 status;
        logic [FILL_BITS-1:0]    fill_count;
    } out_item_t;

    // Broadcast to every cell of the row
    typedef struct packed {
        cell_op_t             op;
        logic [WORD_BITS-1:0] word;
    } cell_cmd_t;

endpackage

[rtl/bdq_cell.sv]
// ----------------------------------------------------------------------------
// bdq_cell: one storage cell of the deque row
// Holds one word and its valid flag; shifts with its neighbors on front
// operations, fills or empties in place on back operations.
// ----------------------------------------------------------------------------
module bdq_cell (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  bdq_pkg::cell_cmd_t           cmd,
    input  logic                         left_valid,
    input  logic [bdq_pkg::WORD_BITS-1:0] left_word,
    input  logic                         right_valid,
    input  logic [bdq_pkg::WORD_BITS-1:0] right_word,
    output logic                         valid,
    output logic [bdq_pkg::WORD_BITS-1:0] word,
    output logic [bdq_pkg::WORD_BITS-1:0] tap
);
    import bdq_pkg::*;

    logic                 valid_reg, valid_next;
    logic [WORD_BITS-1:0] word_reg, word_next;
    logic                 is_last;

    assign is_last = valid_reg && !right_valid;

    always_comb begin
        valid_next = valid_reg;
        word_next  = word_reg;
        case (cmd.op)
            OP_BACK_PUSH: begin
                // first empty slot takes the new word
                if (!valid_reg && left_valid) begin
                    valid_next = 1'b1;
                    word_next  = cmd.word;
                end
            end
            OP_FRONT_PUSH: begin
                valid_next = left_valid;
                word_next  = left_word;
            end
            OP_BACK_POP: begin
                if (is_last) begin
                    valid_next = 1'b0;
                end
            end
            OP_FRONT_POP: begin
                valid_next = right_valid;
                word_next  = right_word;
            end
            default: begin
                valid_next = valid_reg;
                word_next  = word_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    assign valid = valid_reg;
    assign word  = word_reg;
    assign tap   = is_last ? word_reg : '0;

endmodule

[rtl/bdq_tap_tree.sv]
// ----------------------------------------------------------------------------
// bdq_tap_tree: back-word collector
// ORs the one-hot gated cell taps in groups into registers, then folds
// the group registers into the back word.
// ----------------------------------------------------------------------------
module bdq_tap_tree (
    input  logic                          aclk,
    input  logic                          capture,
    input  logic [bdq_pkg::WORD_BITS-1:0] taps [bdq_pkg::DEPTH],
    output logic [bdq_pkg::WORD_BITS-1:0] back_word
);
    import bdq_pkg::*;

    logic [WORD_BITS-1:0] group_reg [GROUPS];

    always_ff @(posedge aclk) begin
        logic [WORD_BITS-1:0] acc;
        if (capture) begin
            for (int g = 0; g < GROUPS; g++) begin
                acc = '0;
                for (int j = 0; j < GROUP_SIZE; j++) begin
                    if (g * GROUP_SIZE + j < DEPTH) begin
                        acc = acc | taps[g * GROUP_SIZE + j];
                    end
                end
                group_reg[g] <= acc;
            end
        end
    end

    always_comb begin
        back_word = '0;
        for (int g = 0; g < GROUPS; g++) begin
            back_word = back_word | group_reg[g];
        end
    end

endmodule

[rtl/bounded_double_ended_queue_core.sv]
// ----------------------------------------------------------------------------
// bounded_double_ended_queue_core: bounded deque on a row of shift cells
// Each accepted beat is registered (command, status, fill count, front word
// and tap-tree groups); in S_FIN the back-word groups are folded into the
// result, which loads into the output register once that is free. No new
// beat is taken until then. Reset (synchronous, aresetn low): queue empty,
// capacity 100; no clearing pass, items are taken as soon as reset ends.
// ----------------------------------------------------------------------------
module bounded_double_ended_queue_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  bdq_pkg::in_item_t           s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output bdq_pkg::out_item_t          m_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [bdq_pkg::CAP_BITS-1:0] cfg_data
);
    import bdq_pkg::*;

    state_t               state_reg, state_next;
    logic [CAP_BITS-1:0]  capacity_reg;
    logic [CNT_W-1:0]     count_reg, count_next;
    cmd_t                 res_cmd_reg;
    status_t              res_status_reg, status_now;
    logic [FILL_BITS-1:0] res_count_reg;
    logic [WORD_BITS-1:0] front_reg;
    logic                 m_valid_reg;
    out_item_t            m_data_reg;

    logic                 accept, load_out, is_push, ok;
    logic [LIM_W-1:0]     cap_ext, limit;
    cell_cmd_t            cell_cmd;
    logic [DEPTH-1:0]     cell_valid;
    logic [WORD_BITS-1:0] cell_word [DEPTH];
    logic [WORD_BITS-1:0] cell_tap  [DEPTH];
    logic [WORD_BITS-1:0] back_word;
    logic [WORD_BITS-1:0] res_word;

    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;

    // Limit saturates at the row length
    assign cap_ext = LIM_W'(capacity_reg);
    assign limit   = (cap_ext > LIM_W'(DEPTH)) ? LIM_W'(DEPTH) : cap_ext;
    assign is_push = (s_data.cmd == CMD_BACK_PUSH) || (s_data.cmd == CMD_FRONT_PUSH);

    always_comb begin
        if (is_push) begin
            ok         = LIM_W'(count_reg) < limit;
            status_now = ok ? ST_OK : ST_FULL;
        end else begin
            ok         = count_reg != '0;
            status_now = ok ? ST_OK : ST_EMPTY;
        end
    end

    always_comb begin
        cell_cmd.op   = OP_HOLD;
        cell_cmd.word = WORD_BITS'(s_data.push_word);
        count_next    = count_reg;
        if (accept && ok) begin
            case (s_data.cmd)
                CMD_BACK_PUSH: begin
                    cell_cmd.op = OP_BACK_PUSH;
                    count_next  = count_reg + 1'b1;
                end
                CMD_FRONT_PUSH: begin
                    cell_cmd.op = OP_FRONT_PUSH;
                    count_next  = count_reg + 1'b1;
                end
                CMD_BACK_POP: begin
                    cell_cmd.op = OP_BACK_POP;
                    count_next  = count_reg - 1'b1;
                end
                CMD_FRONT_POP: begin
                    cell_cmd.op = OP_FRONT_POP;
                    count_next  = count_reg - 1'b1;
                end
                default: begin
                    cell_cmd.op = OP_HOLD;
                end
            endcase
        end
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic                 lv, rv;
        logic [WORD_BITS-1:0] lw, rw;
        if (i == 0) begin : g_head
            assign lv = 1'b1;
            assign lw = cell_cmd.word;
        end else begin : g_mid_l
            assign lv = cell_valid[i-1];
            assign lw = cell_word[i-1];
        end
        if (i == DEPTH - 1) begin : g_tail
            assign rv = 1'b0;
            assign rw = '0;
        end else begin : g_mid_r
            assign rv = cell_valid[i+1];
            assign rw = cell_word[i+1];
        end
        bdq_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .cmd         (cell_cmd),
            .left_valid  (lv),
            .left_word   (lw),
            .right_valid (rv),
            .right_word  (rw),
            .valid       (cell_valid[i]),
            .word        (cell_word[i]),
            .tap         (cell_tap[i])
        );
    end

    bdq_tap_tree u_tap_tree (
        .aclk      (aclk),
        .capture   (accept),
        .taps      (cell_tap),
        .back_word (back_word)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb begin
        s_ready  = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
            end
            S_FIN: begin
                load_out = !m_valid_reg || m_ready;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        res_word = '0;
        if (res_status_reg == ST_OK) begin
            if (res_cmd_reg == CMD_BACK_POP) begin
                res_word = back_word;
            end else if (res_cmd_reg == CMD_FRONT_POP) begin
                res_word = front_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            capacity_reg <= CAPACITY_RESET;
            count_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_valid && cfg_ready) begin
                capacity_reg <= cfg_data;
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            res_cmd_reg    <= s_data.cmd;
            res_status_reg <= status_now;
            res_count_reg  <= FILL_BITS'(count_next);
            front_reg      <= cell_word[0];
        end
        if (load_out) begin
            m_data_reg.pop_word   <= PAYLOAD_BITS'(res_word);
            m_data_reg.status     <= res_status_reg;
            m_data_reg.fill_count <= res_count_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Occupied cells form one run from the front; their number matches the count
    a_valid_run: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(cell_valid) == count_reg)
        else $error("cell valid flags disagree with count");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("count beyond row length");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("second beat taken before result staged");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status != ST_OK) |-> m_data.pop_word == '0)
        else $error("failed operation returned a word");

    a_fail_no_move: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !ok |=> $stable(count_reg) && $stable(cell_valid))
        else $error("failed operation changed the queue");

endmodule
